// ===== hdl/line_rasterizer_with_slope_glyph_macros.svh =====
// shared assertion forms, clocked on the rising edge, quiet while in reset
`ifndef LINE_RASTERIZER_WITH_SLOPE_GLYPH_MACROS_SVH
`define LINE_RASTERIZER_WITH_SLOPE_GLYPH_MACROS_SVH

// consequent checked in the same cycle
`define LRSG_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LRSG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrsg_pkg.sv =====
`timescale 1ns / 1ps

package lrsg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SCREEN_BITS    = 12;
    localparam int CFG_INDEX_BITS = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SCREEN_BITS-1:0] SCREEN_RESET = SCREEN_BITS'(512);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    typedef enum logic [1:0] {
        GLYPH_DASH      = 2'd0,
        GLYPH_BAR       = 2'd1,
        GLYPH_BACKSLASH = 2'd2,
        GLYPH_SLASH     = 2'd3
    } glyph_t;

endpackage

// ===== hdl/lrsg_fifo.sv =====
`timescale 1ns / 1ps
`include "line_rasterizer_with_slope_glyph_macros.svh"

module lrsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lrsg_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);
    import lrsg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

    `LRSG_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
        "fifo count beyond depth")
    `LRSG_ASSERT_NEXT(a_push_grows, clk, rst_n, do_push && !do_pop,
        count_reg == $past(count_reg) + CW'(1), "push alone did not add a word")
    `LRSG_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, do_pop && !do_push,
        count_reg == $past(count_reg) - CW'(1), "pop alone did not remove a word")

endmodule

// ===== hdl/lrsg_front.sv =====
`timescale 1ns / 1ps

module lrsg_front #(
    parameter int COORD_BITS = lrsg_pkg::COORD_BITS_DEF
) (
    input  logic                         push,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         full,
    output logic                         q_push,
    output logic [6*COORD_BITS+4:0]      q_word,
    input  logic                         q_full
);
    import lrsg_pkg::*;

    localparam int N = COORD_BITS;

    logic signed [N:0] diff_x;
    logic signed [N:0] diff_y;
    logic [N-1:0]      dx;
    logic [N-1:0]      dy;
    logic              dx_neg;
    logic              dy_neg;
    glyph_t            glyph;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        diff_x = (N+1)'(x_end) - (N+1)'(x_start);
        diff_y = (N+1)'(y_end) - (N+1)'(y_start);
        // negative step unless the end is strictly greater
        dx_neg = !(x_start < x_end);
        dy_neg = !(y_start < y_end);
        dx     = dx_neg ? N'(-diff_x) : N'(diff_x);
        dy     = dy_neg ? N'(-diff_y) : N'(diff_y);

        if ({1'b0, dx} > {dy, 1'b0})
        begin
            glyph = GLYPH_DASH;
        end
        else if ({1'b0, dy} > {dx, 1'b0})
        begin
            glyph = GLYPH_BAR;
        end
        else if (dx_neg == dy_neg)
        begin
            glyph = GLYPH_BACKSLASH;
        end
        else
        begin
            glyph = GLYPH_SLASH;
        end
    end

    assign q_word = {glyph, dy_neg, dx_neg, dy, dx, y_end, x_end, y_start, x_start, cmd};

endmodule

// ===== hdl/lrsg_back.sv =====
`timescale 1ns / 1ps
`include "line_rasterizer_with_slope_glyph_macros.svh"

module lrsg_back #(
    parameter int COORD_BITS = lrsg_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lrsg_pkg::SCREEN_BITS-1:0] screen_width,
    input  logic [lrsg_pkg::SCREEN_BITS-1:0] screen_height,
    input  logic                             cmd_empty,
    input  logic [6*COORD_BITS+4:0]          cmd_word,
    output logic                             cmd_pop,
    input  logic                             res_full,
    output logic                             res_push,
    output logic [2*COORD_BITS+4:0]          res_word
);
    import lrsg_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int EW = N + 2;
    localparam int SW = N + 3;
    localparam int MW = (N - 1 > SCREEN_BITS) ? N - 1 : SCREEN_BITS;

    // queued word fields
    logic         w_cmd;
    logic [N-1:0] w_x0, w_y0, w_x1, w_y1, w_dx, w_dy;
    logic         w_dx_neg, w_dy_neg;
    logic [1:0]   w_glyph;

    // line state
    logic [N-1:0]  cur_col_reg, cur_col_next;
    logic [N-1:0]  cur_row_reg, cur_row_next;
    logic [N-1:0]  goal_col_reg, goal_col_next;
    logic [N-1:0]  goal_row_reg, goal_row_next;
    logic [N-1:0]  dx_reg, dx_next;
    logic [N-1:0]  dy_reg, dy_next;
    logic          dx_neg_reg, dx_neg_next;
    logic          dy_neg_reg, dy_neg_next;
    logic [EW-1:0] err_reg, err_next;
    logic [1:0]    glyph_reg, glyph_next;
    logic          busy_reg, busy_next;

    logic                 go;
    logic                 is_start;
    logic signed [SW-1:0] e2, dx_ext, dy_ext, err_sum;
    logic                 step_x, step_y;
    logic [N-1:0]         col_new, row_new;
    logic                 at_goal;
    logic                 on_screen;
    logic                 res_valid, res_we, res_last;
    logic [N-1:0]         res_x, res_y;
    logic [1:0]           res_glyph;

    assign {w_glyph, w_dy_neg, w_dx_neg, w_dy, w_dx, w_y1, w_x1, w_y0, w_x0, w_cmd} = cmd_word;

    assign go       = !cmd_empty && !res_full;
    assign cmd_pop  = go;
    assign res_push = go;
    assign is_start = (w_cmd == CMD_START);

    // one bresenham step from the stored state
    always_comb
    begin
        e2      = $signed({err_reg, 1'b0});
        dx_ext  = $signed({3'b000, dx_reg});
        dy_ext  = $signed({3'b000, dy_reg});
        step_x  = e2 > -dy_ext;
        step_y  = e2 < dx_ext;
        err_sum = $signed({err_reg[EW-1], err_reg})
                  - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
    end

    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        goal_col_next = goal_col_reg;
        goal_row_next = goal_row_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dx_neg_next   = dx_neg_reg;
        dy_neg_next   = dy_neg_reg;
        err_next      = err_reg;
        glyph_next    = glyph_reg;
        busy_next     = busy_reg;

        if (is_start)
        begin
            col_new = w_x0;
            row_new = w_y0;
            at_goal = (w_x0 == w_x1) && (w_y0 == w_y1);
        end
        else
        begin
            col_new = cur_col_reg + (step_x ? (dx_neg_reg ? '1 : N'(1)) : '0);
            row_new = cur_row_reg + (step_y ? (dy_neg_reg ? '1 : N'(1)) : '0);
            at_goal = (col_new == goal_col_reg) && (row_new == goal_row_reg);
        end

        on_screen = !col_new[N-1] && !row_new[N-1]
                    && (MW'(col_new[N-2:0]) < MW'(screen_width))
                    && (MW'(row_new[N-2:0]) < MW'(screen_height));

        res_valid = is_start || busy_reg;
        res_x     = res_valid ? col_new : '0;
        res_y     = res_valid ? row_new : '0;
        res_glyph = is_start ? w_glyph : (busy_reg ? glyph_reg : GLYPH_DASH);
        res_we    = res_valid && on_screen;
        res_last  = res_valid && at_goal;

        if (go)
        begin
            if (is_start)
            begin
                cur_col_next  = w_x0;
                cur_row_next  = w_y0;
                goal_col_next = w_x1;
                goal_row_next = w_y1;
                dx_next       = w_dx;
                dy_next       = w_dy;
                dx_neg_next   = w_dx_neg;
                dy_neg_next   = w_dy_neg;
                err_next      = EW'($signed({2'b00, w_dx}) - $signed({2'b00, w_dy}));
                glyph_next    = w_glyph;
                busy_next     = !at_goal;
            end
            else if (busy_reg)
            begin
                cur_col_next = col_new;
                cur_row_next = row_new;
                err_next     = err_sum[EW-1:0];
                busy_next    = !at_goal;
            end
        end
    end

    assign res_word = {res_last, res_valid, res_we, res_glyph, res_y, res_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            goal_col_reg <= '0;
            goal_row_reg <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dx_neg_reg   <= 1'b0;
            dy_neg_reg   <= 1'b0;
            err_reg      <= '0;
            glyph_reg    <= GLYPH_DASH;
            busy_reg     <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            goal_col_reg <= goal_col_next;
            goal_row_reg <= goal_row_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dx_neg_reg   <= dx_neg_next;
            dy_neg_reg   <= dy_neg_next;
            err_reg      <= err_next;
            glyph_reg    <= glyph_next;
            busy_reg     <= busy_next;
        end
    end

    `LRSG_ASSERT_NOW(a_busy_off_goal, clk, rst_n, busy_reg,
        (cur_col_reg != goal_col_reg) || (cur_row_reg != goal_row_reg),
        "line busy while sitting on its endpoint")
    `LRSG_ASSERT_NEXT(a_last_ends_line, clk, rst_n, res_push && res_last, !busy_reg,
        "line still busy after its last pixel")
    `LRSG_ASSERT_NOW(a_idle_word_quiet, clk, rst_n, res_push && !res_valid,
        !res_we && !res_last, "inactive word carries enable or last")
    `LRSG_ASSERT_NEXT(a_idle_advance_stays, clk, rst_n, go && !is_start && !busy_reg,
        !busy_reg && $stable(cur_col_reg) && $stable(cur_row_reg),
        "advance while idle changed the line")

endmodule

// ===== hdl/line_rasterizer_with_slope_glyph.sv =====
`timescale 1ns / 1ps
// path: a pushed word is registered in the command queue, stepped, then registered in the result queue
// throughput: one word per cycle while no queue stalls; each step is one add and compare of the line state
// the command and result queues are two words deep, so either side may stall alone
// reset (rst_n low, asynchronous): both queues empty, no line active, screen 512 x 512

module line_rasterizer_with_slope_glyph #(
    parameter int COORD_BITS = lrsg_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                cmd,
    input  logic signed [COORD_BITS-1:0]        x_start,
    input  logic signed [COORD_BITS-1:0]        y_start,
    input  logic signed [COORD_BITS-1:0]        x_end,
    input  logic signed [COORD_BITS-1:0]        y_end,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS-1:0]        pixel_y,
    output logic [1:0]                          glyph,
    output logic                                write_enable,
    output logic                                pixel_valid,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lrsg_pkg::SCREEN_BITS-1:0]    cfg_data
);
    import lrsg_pkg::*;

    localparam int CMD_W = 6 * COORD_BITS + 5;
    localparam int RES_W = 2 * COORD_BITS + 5;

    logic [SCREEN_BITS-1:0] width_reg, width_next;
    logic [SCREEN_BITS-1:0] height_reg, height_next;

    logic             q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0] q_word_in, q_word_out;
    logic             r_push, r_full;
    logic [RES_W-1:0] r_word_in, r_word_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_next  = cfg_data;
                REG_SCREEN_HEIGHT: height_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_RESET;
            height_reg <= SCREEN_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    lrsg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .push    (push),
        .cmd     (cmd),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .full    (full),
        .q_push  (q_push),
        .q_word  (q_word_in),
        .q_full  (q_full)
    );

    lrsg_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_word_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_word_out),
        .empty    (q_empty)
    );

    lrsg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .cmd_empty     (q_empty),
        .cmd_word      (q_word_out),
        .cmd_pop       (q_pop),
        .res_full      (r_full),
        .res_push      (r_push),
        .res_word      (r_word_in)
    );

    lrsg_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (r_push),
        .data_in  (r_word_in),
        .full     (r_full),
        .pop      (pop),
        .data_out (r_word_out),
        .empty    (empty)
    );

    assign {last, pixel_valid, write_enable, glyph, pixel_y, pixel_x} = r_word_out;

endmodule

// ===== sim/tb_line_rasterizer_with_slope_glyph.sv =====
`timescale 1ns / 1ps

module tb_line_rasterizer_with_slope_glyph;
    import lrsg_pkg::*;

    localparam int CW = COORD_BITS_DEF;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        glyph_t               gl;
        logic                 we;
        logic                 pv;
        logic                 lst;
    } pixel_word_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    logic                      full;
    logic                      cmd       = CMD_ADVANCE;
    logic signed [CW-1:0]      x_start   = '0;
    logic signed [CW-1:0]      y_start   = '0;
    logic signed [CW-1:0]      x_end     = '0;
    logic signed [CW-1:0]      y_end     = '0;
    logic                      empty;
    logic                      pop       = 1'b0;
    logic signed [CW-1:0]      pixel_x;
    logic signed [CW-1:0]      pixel_y;
    logic [1:0]                glyph;
    logic                      write_enable;
    logic                      pixel_valid;
    logic                      last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0]    cfg_data  = SCREEN_RESET;

    // line tracker mirrored on the testbench side
    int     scr_width  = int'(SCREEN_RESET);
    int     scr_height = int'(SCREEN_RESET);
    int     trk_col, trk_row, tgt_col, tgt_row;
    int     span_col, span_row, bres_err;
    bit     col_down, row_down, trk_active;
    glyph_t trk_glyph = GLYPH_DASH;

    pixel_word_t pending_pixels[$];
    int          fail_count   = 0;
    int          items_sent   = 0;
    bit          idle_on      = 1'b1;
    int          hold_request = 0;

    line_rasterizer_with_slope_glyph #(.COORD_BITS(CW)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .empty        (empty),
        .pop          (pop),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .glyph        (glyph),
        .write_enable (write_enable),
        .pixel_valid  (pixel_valid),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int near_edge(input int lim);
        int base;
        base = $urandom_range(0, 1) ? 0 : lim;
        return clamp_coord(base + int'($urandom_range(0, 16)) - 8);
    endfunction

    // bresenham step on the mirrored state; gives the word the block must return
    function automatic pixel_word_t predict_pixel(input logic c,
            input logic signed [CW-1:0] xs, ys, xe, ye);
        pixel_word_t p;
        int          e2;
        p.px  = '0;
        p.py  = '0;
        p.gl  = GLYPH_DASH;
        p.we  = 1'b0;
        p.pv  = 1'b0;
        p.lst = 1'b0;
        if (c == CMD_START)
        begin
            trk_col  = xs;
            trk_row  = ys;
            tgt_col  = xe;
            tgt_row  = ye;
            span_col = (tgt_col > trk_col) ? tgt_col - trk_col : trk_col - tgt_col;
            span_row = (tgt_row > trk_row) ? tgt_row - trk_row : trk_row - tgt_row;
            // equal coordinates count as a negative step
            col_down = !(trk_col < tgt_col);
            row_down = !(trk_row < tgt_row);
            bres_err = span_col - span_row;
            if (span_col > 2 * span_row)
                trk_glyph = GLYPH_DASH;
            else if (span_row > 2 * span_col)
                trk_glyph = GLYPH_BAR;
            else if (col_down == row_down)
                trk_glyph = GLYPH_BACKSLASH;
            else
                trk_glyph = GLYPH_SLASH;
        end
        else if (!trk_active)
        begin
            return p;
        end
        else
        begin
            e2 = 2 * bres_err;
            if (e2 > -span_row)
            begin
                bres_err -= span_row;
                trk_col  += col_down ? -1 : 1;
            end
            if (e2 < span_col)
            begin
                bres_err += span_col;
                trk_row  += row_down ? -1 : 1;
            end
        end
        p.lst      = (trk_col == tgt_col) && (trk_row == tgt_row);
        trk_active = !p.lst;
        p.px       = CW'(trk_col);
        p.py       = CW'(trk_row);
        p.gl       = trk_glyph;
        p.pv       = 1'b1;
        p.we       = trk_col >= 0 && trk_row >= 0 &&
                     trk_col < scr_width && trk_row < scr_height;
        return p;
    endfunction

    task automatic send_cmd(input logic c, input int xs, ys, xe, ye);
        int          gap;
        pixel_word_t exp_p;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        cmd     <= c;
        x_start <= CW'(xs);
        y_start <= CW'(ys);
        x_end   <= CW'(xe);
        y_end   <= CW'(ye);
        do
            @(posedge clk);
        while (full);
        items_sent++;
        exp_p          = predict_pixel(c, CW'(xs), CW'(ys), CW'(xe), CW'(ye));
        pending_pixels = {pending_pixels, exp_p};
    endtask

    task automatic draw_line(input int xs, ys, xe, ye, input int max_steps);
        int n;
        n = 0;
        send_cmd(CMD_START, xs, ys, xe, ye);
        while (trk_active && n < max_steps)
        begin
            send_cmd(CMD_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord());
            n++;
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_screen(input int w, h);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= SCREEN_BITS'(w);
        do
            @(posedge clk);
        while (!cfg_ready);
        scr_width = w & 'hFFF;
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= SCREEN_BITS'(h);
        do
            @(posedge clk);
        while (!cfg_ready);
        scr_height = h & 'hFFF;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // advance with no line running
        send_cmd(CMD_ADVANCE, 2047, -2048, 2047, -2048);
        // single-point lines, one at the coordinate extremes
        draw_line(5, 5, 5, 5, 4);
        draw_line(-2048, 2047, -2048, 2047, 4);
        // one line per glyph; the dash crosses the left and bottom clip edges
        draw_line(-2, 511, 2, 512, 8);
        draw_line(3, 0, 3, 3, 8);
        draw_line(1, 1, 3, 3, 8);
        draw_line(4, 0, 2, 2, 8);
        // restart in the middle of a running line
        draw_line(-2048, -2048, 2047, 2047, 2);
        draw_line(2047, -2048, -2048, 2047, 1);
        draw_line(0, 0, -1, -1, 4);
        send_cmd(CMD_ADVANCE, -1, -1, 0, 0);
    endtask

    task automatic test_screen_limits();
        set_screen(0, 0);
        draw_line(-1, -1, 2, 1, 8);
        set_screen(1, 1);
        draw_line(-1, -1, 1, 1, 8);
        set_screen(4095, 4095);
        draw_line(2047, 2047, 2040, 2045, 16);
        draw_line(-1, 0, 3, 0, 8);
        set_screen(2048, 1);
        draw_line(2045, -1, 2047, 1, 8);
    endtask

    task automatic test_full_span_line();
        set_screen(2048, 2);
        // widest column delta, error term near its largest value
        idle_on = 1'b0;
        draw_line(-2048, 0, 2047, 3, 40);
        idle_on = 1'b1;
        draw_line(5, -2048, 6, 2047, 40);
    endtask

    task automatic test_backpressure();
        // sink holds off while words keep coming, so the queues fill up
        idle_on      = 1'b0;
        hold_request = 300;
        draw_line(100, 100, 160, 130, 100);
        idle_on      = 1'b1;
    endtask

    task automatic test_random_lines(input int total);
        int first, phase, xs, ys, xe, ye, span, steps, r;
        first = items_sent;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_screen(640, 480);
                1: set_screen(2048, 2048);
                2: set_screen(1, 2048);
                3: set_screen($urandom_range(1, 2048), $urandom_range(1, 2048));
                default: set_screen(32, 24);
            endcase
            while (items_sent < first + (phase + 1) * total / 5)
            begin
                r    = $urandom_range(0, 99);
                span = $urandom_range(0, 49);
                span = (span == 0) ? 300 : (span < 6) ? 60 : 10;
                if (r < 55)
                begin
                    xs = near_edge(scr_width);
                    ys = near_edge(scr_height);
                end
                else
                begin
                    xs = any_coord();
                    ys = any_coord();
                end
                if (r < 88)
                begin
                    xe    = clamp_coord(xs + int'($urandom_range(0, 2 * span)) - span);
                    ye    = clamp_coord(ys + int'($urandom_range(0, 2 * span)) - span);
                    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5000;
                end
                else
                begin
                    // far endpoints, dropped after a few pixels
                    xe    = any_coord();
                    ye    = any_coord();
                    steps = $urandom_range(0, 30);
                end
                draw_line(xs, ys, xe, ye, steps);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 2))
                        send_cmd(CMD_ADVANCE, any_coord(), any_coord(), any_coord(),
                                 any_coord());
                if ($urandom_range(0, 39) == 0)
                    idle_on = !idle_on;
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: random pop stalls, compares each accepted word
    initial
    begin : pixel_sink
        int          stall_left;
        pixel_word_t exp_w;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected word: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
                    fail_count++;
                end
                else
                begin
                    exp_w = pending_pixels.pop_front();
                    if (pixel_x !== exp_w.px)
                    begin
                        $error("pixel_x: expected %0d, actual %0d", exp_w.px, pixel_x);
                        fail_count++;
                    end
                    if (pixel_y !== exp_w.py)
                    begin
                        $error("pixel_y: expected %0d, actual %0d", exp_w.py, pixel_y);
                        fail_count++;
                    end
                    if (glyph !== exp_w.gl)
                    begin
                        $error("glyph: expected %0d, actual %0d", exp_w.gl, glyph);
                        fail_count++;
                    end
                    if (write_enable !== exp_w.we)
                    begin
                        $error("write_enable: expected %0d, actual %0d", exp_w.we,
                               write_enable);
                        fail_count++;
                    end
                    if (pixel_valid !== exp_w.pv)
                    begin
                        $error("pixel_valid: expected %0d, actual %0d", exp_w.pv,
                               pixel_valid);
                        fail_count++;
                    end
                    if (last !== exp_w.lst)
                    begin
                        $error("last: expected %0d, actual %0d", exp_w.lst, last);
                        fail_count++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (idle_on)
            begin
                stall_left = pick_gap();
                pop <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_screen_limits();
        test_full_span_line();
        test_backpressure();
        test_random_lines(1500);
        settle();
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
